// File: sv/entity_pool_allocator_assert.svh
// assertion macros shared by the checker
`ifndef ENTITY_POOL_ALLOCATOR_ASSERT_SVH
`define ENTITY_POOL_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, idle during reset
`define EPA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, idle during reset
`define EPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/epa_pkg.sv
package epa_pkg;

    // default sizes
    localparam int DEF_POOL_ENTRIES   = 64;
    localparam int DEF_PROPERTY_COUNT = 64;

    // fixed field widths
    localparam int ENTRY_W  = 6;
    localparam int PROP_W   = 6;
    localparam int STATUS_W = 2;
    localparam int FREE_W   = 7;
    localparam int OPCODE_W = 3;

    // entries reachable through the 6-bit index field
    localparam int ENTRY_SPAN = 1 << ENTRY_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC = 3'd0,
        OP_FREE  = 3'd1,
        OP_SET   = 3'd2,
        OP_CLEAR = 3'd3,
        OP_TEST  = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK          = 2'd0,
        STAT_EMPTY       = 2'd1,
        STAT_NOT_IN_USE  = 2'd2
    } status_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [ENTRY_W-1:0]  entry_index;
        logic [PROP_W-1:0]   property_number;
    } in_item_t;

    typedef struct packed {
        logic [ENTRY_W-1:0]  result_index;
        logic [STATUS_W-1:0] status;
        logic                property_value;
        logic [FREE_W-1:0]   free_entries;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic issue;
        logic commit;
    } epa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_full;
    } epa_stat_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

// File: sv/epa_ctrl.sv
module epa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_ready,
    input  epa_pkg::epa_stat_t stat,
    output epa_pkg::epa_cmd_t cmd
);
    import epa_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   slot_free;

    // result slot can take a result this cycle
    assign slot_free = !stat.out_full || out_ready;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready   = 1'b0;
        cmd.issue  = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.issue = in_valid;
            end
            S_EXEC:
            begin
                cmd.commit = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/epa_datapath.sv
module epa_datapath #(
    parameter int POOL_ENTRIES   = epa_pkg::DEF_POOL_ENTRIES,
    parameter int PROPERTY_COUNT = epa_pkg::DEF_PROPERTY_COUNT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  epa_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output epa_pkg::out_item_t out_data,
    input  epa_pkg::epa_cmd_t  cmd,
    output epa_pkg::epa_stat_t stat
);
    import epa_pkg::*;

    localparam int QA_W       = $clog2(POOL_ENTRIES);
    localparam int CNT_W      = $clog2(POOL_ENTRIES + 1);
    localparam int PROP_DEPTH = (POOL_ENTRIES < ENTRY_SPAN) ? POOL_ENTRIES : ENTRY_SPAN;
    localparam int PA_W       = $clog2(PROP_DEPTH);
    localparam int PB_W       = (PROPERTY_COUNT > 1) ? $clog2(PROPERTY_COUNT) : 1;

    // free queue and property rows
    logic [QA_W-1:0]           qmem [POOL_ENTRIES];
    logic [PROPERTY_COUNT-1:0] pmem [PROP_DEPTH];

    logic [QA_W-1:0]           head_reg, head_next;
    logic [QA_W-1:0]           tail_reg, tail_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      wrapped_reg, wrapped_next;
    logic [PROP_DEPTH-1:0]     in_use_reg, in_use_next;
    logic [PROP_DEPTH-1:0]     row_valid_reg, row_valid_next;

    in_item_t                  item_reg;
    logic [QA_W-1:0]           q_rd_reg;
    logic [PROPERTY_COUNT-1:0] p_rd_reg;
    logic                      q_written_reg;

    logic                      out_valid_reg;
    out_item_t                 out_data_reg;
    out_item_t                 result;

    logic [ENTRY_W-1:0]        entry;
    logic [PA_W-1:0]           ea;
    logic [PB_W-1:0]           pb;
    logic                      entry_ok;
    logic                      prop_ok;
    logic [QA_W-1:0]           head_val;
    logic                      head_in_span;
    logic [PROPERTY_COUNT-1:0] row;
    logic [PROPERTY_COUNT-1:0] bit_mask;
    logic [PROPERTY_COUNT-1:0] row_wdata;
    logic                      alloc_do;
    logic                      free_do;
    logic                      row_wr;

    // operand decode of the held item
    assign entry    = item_reg.entry_index;
    assign ea       = entry[PA_W-1:0];
    assign pb       = item_reg.property_number[PB_W-1:0];
    assign entry_ok = {1'b0, entry} < (ENTRY_W + 1)'(PROP_DEPTH);
    assign prop_ok  = {1'b0, item_reg.property_number} < (PROP_W + 1)'(PROPERTY_COUNT);
    assign bit_mask = PROPERTY_COUNT'(1) << pb;

    // queue slots never written still hold their own position
    assign head_val     = q_written_reg ? q_rd_reg : head_reg;
    assign head_in_span = {1'b0, head_val} < (QA_W + 1)'(PROP_DEPTH);

    // a row without its valid bit reads as cleared
    assign row = row_valid_reg[ea] ? p_rd_reg : '0;

    // operation decode and result
    always_comb
    begin
        alloc_do              = 1'b0;
        free_do               = 1'b0;
        row_wr                = 1'b0;
        row_wdata             = row;
        result.result_index   = entry;
        result.status         = STAT_OK;
        result.property_value = 1'b0;
        case (item_reg.opcode)
            OP_ALLOC:
            begin
                if (count_reg == '0)
                begin
                    result.status = STAT_EMPTY;
                end
                else
                begin
                    alloc_do            = 1'b1;
                    result.result_index = ENTRY_W'(head_val);
                end
            end
            OP_FREE:
            begin
                if (entry_ok && in_use_reg[ea])
                begin
                    free_do = 1'b1;
                end
                else
                begin
                    result.status = STAT_NOT_IN_USE;
                end
            end
            OP_SET:
            begin
                row_wr    = entry_ok && prop_ok;
                row_wdata = row | bit_mask;
            end
            OP_CLEAR:
            begin
                row_wr    = entry_ok && prop_ok;
                row_wdata = row & ~bit_mask;
            end
            OP_TEST:
            begin
                result.property_value = entry_ok && prop_ok && row[pb];
            end
            default:
            begin
                result.status = STAT_OK;
            end
        endcase
        result.free_entries = FREE_W'(count_next);
    end

    // queue pointers, count and per-entry flags
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        wrapped_next   = wrapped_reg;
        in_use_next    = in_use_reg;
        row_valid_next = row_valid_reg;
        if (alloc_do)
        begin
            head_next  = (head_reg == QA_W'(POOL_ENTRIES - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
            if (head_in_span)
            begin
                in_use_next[head_val[PA_W-1:0]]    = 1'b1;
                row_valid_next[head_val[PA_W-1:0]] = 1'b0;
            end
        end
        if (free_do)
        begin
            tail_next  = (tail_reg == QA_W'(POOL_ENTRIES - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
            if (tail_reg == QA_W'(POOL_ENTRIES - 1))
            begin
                wrapped_next = 1'b1;
            end
            in_use_next[ea]    = 1'b0;
            row_valid_next[ea] = 1'b0;
        end
        if (row_wr)
        begin
            row_valid_next[ea] = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= CNT_W'(POOL_ENTRIES);
            wrapped_reg   <= 1'b0;
            in_use_reg    <= '0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                count_reg     <= count_next;
                wrapped_reg   <= wrapped_next;
                in_use_reg    <= in_use_next;
                row_valid_reg <= row_valid_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item capture and result register
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            item_reg      <= in_data;
            q_written_reg <= wrapped_reg || (head_reg < tail_reg);
        end
        if (cmd.commit)
        begin
            out_data_reg <= result;
        end
    end

    // free queue memory
    always_ff @(posedge clk)
    begin
        if (cmd.commit && free_do)
        begin
            qmem[tail_reg] <= QA_W'(entry);
        end
        if (cmd.issue)
        begin
            q_rd_reg <= qmem[head_reg];
        end
    end

    // property memory
    always_ff @(posedge clk)
    begin
        if (cmd.commit && row_wr)
        begin
            pmem[ea] <= row_wdata;
        end
        if (cmd.issue)
        begin
            p_rd_reg <= pmem[in_data.entry_index[PA_W-1:0]];
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign stat.out_full = out_valid_reg;

endmodule

// File: sv/entity_pool_allocator.sv
// Pool allocator with a first-in first-out free queue: allocate, free and per-entry
// property set, clear and test, one result per operation. Each operation does the
// registered read of the free queue and property memories in the idle state and then
// the modify and write-back in the execute state; a new operation is accepted only once
// the last one is written back. The result sits in an output register and the next
// operation is taken while it waits, and only a result that is still untaken when the
// following one completes holds the block. There is no clearing pass after reset:
// property rows carry valid bits and the free queue tracks which slots were written.
module entity_pool_allocator #(
    parameter int POOL_ENTRIES   = epa_pkg::DEF_POOL_ENTRIES,
    parameter int PROPERTY_COUNT = epa_pkg::DEF_PROPERTY_COUNT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  epa_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output epa_pkg::out_item_t out_data
);
    import epa_pkg::*;

    epa_cmd_t  cmd;
    epa_stat_t stat;

    // sequencer
    epa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // queue, property store and result register
    epa_datapath #(
        .POOL_ENTRIES   (POOL_ENTRIES),
        .PROPERTY_COUNT (PROPERTY_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// File: sv/epa_checker.sv
`include "entity_pool_allocator_assert.svh"

module epa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input epa_pkg::out_item_t out_data
);
    import epa_pkg::*;

    logic in_xfer;
    logic out_stall;
    logic empty_result;
    logic pool_drained;

    // handshake and result terms
    assign in_xfer      = in_valid && in_ready;
    assign out_stall    = out_valid && !out_ready;
    assign empty_result = out_valid && (out_data.status == STAT_EMPTY);
    assign pool_drained = (out_data.free_entries == '0);

    // one operation in flight: no transfer straight after another
    `EPA_ASSERT_NEXT(a_one_in_flight, in_xfer, !in_ready, "back-to-back input transfer")

    // a fresh result appears only from the execute cycle
    `EPA_ASSERT_IMPL(a_result_from_exec, $rose(out_valid), $past(!in_ready), "stray result")

    // empty pool reports no free entries
    `EPA_ASSERT_IMPL(a_empty_count, empty_result, pool_drained, "empty status with free entries")

    // a stalled result holds
    `EPA_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "stalled result lost")

endmodule

bind entity_pool_allocator epa_checker u_epa_checker (.*);
